@@ rtl/core/wki_pkg.sv @@
// Package for the weighted keyframe interpolator: field widths, register
// indexes, command, value-kind and status codes, reset values. No dependencies.
package wki_pkg;

	localparam int MAX_KEYS_DEF  = 8;
	localparam int FRAC_BITS_DEF = 16;

	localparam int CMD_W      = 1;
	localparam int KIDX_W     = 3;
	localparam int KVAL_W     = 32;
	localparam int WGT_W      = 16;
	localparam int KCNT_W     = 4;
	localparam int KIND_W     = 2;
	localparam int TOT_W      = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int LANE_W     = 2;
	localparam int LANES      = KVAL_W / 8;

	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_KIND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd2;

	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_EVAL  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RGBA  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_INT   = 2'd3;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_RESET  = KIND_INT;
	localparam logic [KCNT_W-1:0] KCNT_RESET  = 4'd2;

endpackage

@@ rtl/core/wki_mem.sv @@
// Keyframe value and segment weight storage, one shared registered read port.
// Depends on wki_pkg.
module wki_mem #(
	parameter int MAX_KEYS = wki_pkg::MAX_KEYS_DEF,
	parameter int IDX_W    = $clog2(MAX_KEYS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_addr,
	input  logic [wki_pkg::KVAL_W-1:0] wr_key,
	input  logic [wki_pkg::WGT_W-1:0]  wr_wgt,
	input  logic                     rd_en,
	input  logic [IDX_W-1:0]         rd_addr,
	output logic [wki_pkg::KVAL_W-1:0] rd_key,
	output logic [wki_pkg::WGT_W-1:0]  rd_wgt
);

	logic [wki_pkg::KVAL_W-1:0] key_mem [MAX_KEYS];
	logic [wki_pkg::WGT_W-1:0]  wgt_mem [MAX_KEYS];
	logic [MAX_KEYS-1:0]        wvld_q;
	logic [wki_pkg::KVAL_W-1:0] rd_key_q;
	logic [wki_pkg::WGT_W-1:0]  rd_wgt_q;

	// Weights read as zero until their slot has been written once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
		end else if (wr_en) begin
			wvld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			wgt_mem[wr_addr] <= wr_wgt;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_wgt_q <= wvld_q[rd_addr] ? wgt_mem[rd_addr] : '0;
		end
	end

	assign rd_key = rd_key_q;
	assign rd_wgt = rd_wgt_q;

endmodule

@@ rtl/core/wki_div.sv @@
// Restoring serial divider for the local segment fraction, one quotient bit
// per cycle. Depends on wki_pkg.
module wki_div #(
	parameter int FRAC_BITS = wki_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [wki_pkg::WGT_W+FRAC_BITS-1:0]   num,
	input  logic [wki_pkg::WGT_W-1:0]             den,
	output logic                                  done,
	output logic [FRAC_BITS:0]                    quo
);

	localparam int FR_W  = FRAC_BITS + 1;
	localparam int NUM_W = wki_pkg::WGT_W + FRAC_BITS;
	localparam int CNT_W = $clog2(FR_W + 1);
	localparam int WW    = wki_pkg::WGT_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WW-1:0]    rem_q;
	logic [WW-1:0]    den_q;
	logic [FR_W-1:0]  nsh_q;
	logic [FR_W-1:0]  quo_q;
	logic [WW:0]      trial;
	logic             qbit;

	// The quotient never exceeds 1.0, so the upper numerator bits already sit
	// below the divisor and only FR_W steps remain.
	assign trial = {rem_q, nsh_q[FR_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FR_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[NUM_W-1:FR_W]};
			nsh_q <= num[FR_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? WW'(trial - {1'b0, den_q}) : trial[WW-1:0];
			nsh_q <= {nsh_q[FR_W-2:0], 1'b0};
			quo_q <= {quo_q[FR_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/core/wki_lerp.sv @@
// Linear interpolation unit: one lane per pass through a shared subtract,
// multiply and add sequence; four lanes for colour. Depends on wki_pkg.
module wki_lerp #(
	parameter int FRAC_BITS = wki_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wki_pkg::KIND_W-1:0]   kind,
	input  logic [wki_pkg::KVAL_W-1:0]   key_a,
	input  logic [wki_pkg::KVAL_W-1:0]   key_b,
	input  logic [FRAC_BITS:0]           t,
	output logic                         done,
	output logic [wki_pkg::KVAL_W-1:0]   result
);

	localparam int FR_W = FRAC_BITS + 1;
	localparam int KW   = wki_pkg::KVAL_W;
	localparam int XW   = KW + 1;
	localparam int PW   = KW + FR_W;

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_PREP = 3'd1;
	localparam logic [2:0] L_MUL  = 3'd2;
	localparam logic [2:0] L_ADD  = 3'd3;
	localparam logic [2:0] L_DONE = 3'd4;

	logic [2:0]                  ph_q;
	logic [wki_pkg::LANE_W-1:0]  lane_q;
	logic [wki_pkg::KIND_W-1:0]  kind_q;
	logic [KW-1:0]               a_q;
	logic [KW-1:0]               b_q;
	logic [FR_W-1:0]             t_q;
	logic                        neg_q;
	logic [KW-1:0]               mag_q;
	logic [XW-1:0]               aex_q;
	logic [PW-1:0]               prod_q;
	logic [KW-1:0]               res_q;

	logic [XW-1:0] a_x;
	logic [XW-1:0] b_x;
	logic [XW-1:0] d;
	logic [XW-1:0] d_neg;
	logic [KW-1:0] q;
	logic [XW-1:0] sq;
	logic [XW-1:0] r;
	logic          last_lane;

	always_comb begin
		case (kind_q)
			wki_pkg::KIND_BYTE: begin
				a_x = XW'(a_q[7:0]);
				b_x = XW'(b_q[7:0]);
			end
			wki_pkg::KIND_SHORT: begin
				a_x = {{(XW-16){a_q[15]}}, a_q[15:0]};
				b_x = {{(XW-16){b_q[15]}}, b_q[15:0]};
			end
			wki_pkg::KIND_RGBA: begin
				a_x = XW'(a_q[lane_q*8 +: 8]);
				b_x = XW'(b_q[lane_q*8 +: 8]);
			end
			default: begin
				a_x = {a_q[KW-1], a_q};
				b_x = {b_q[KW-1], b_q};
			end
		endcase
	end

	assign d         = b_x - a_x;
	assign d_neg     = XW'(0) - d;
	assign q         = prod_q[FRAC_BITS +: KW];
	assign sq        = neg_q ? XW'(0) - {1'b0, q} : {1'b0, q};
	assign r         = aex_q + sq;
	assign last_lane = (kind_q != wki_pkg::KIND_RGBA) ||
		(lane_q == wki_pkg::LANE_W'(wki_pkg::LANES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= L_IDLE;
			lane_q <= '0;
		end else begin
			unique case (ph_q)
				L_IDLE: begin
					if (start) begin
						ph_q   <= L_PREP;
						lane_q <= '0;
					end
				end
				L_PREP: ph_q <= L_MUL;
				L_MUL:  ph_q <= L_ADD;
				L_ADD: begin
					if (last_lane) begin
						ph_q <= L_DONE;
					end else begin
						lane_q <= lane_q + 1'b1;
						ph_q   <= L_PREP;
					end
				end
				L_DONE: ph_q <= L_IDLE;
				default: ph_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == L_IDLE && start) begin
			kind_q <= kind;
			a_q    <= key_a;
			b_q    <= key_b;
			t_q    <= t;
			res_q  <= '0;
		end
		if (ph_q == L_PREP) begin
			neg_q <= d[XW-1];
			mag_q <= d[XW-1] ? d_neg[KW-1:0] : d[KW-1:0];
			aex_q <= a_x;
		end
		if (ph_q == L_MUL) begin
			prod_q <= mag_q * t_q;
		end
		if (ph_q == L_ADD) begin
			if (kind_q == wki_pkg::KIND_RGBA) begin
				res_q[lane_q*8 +: 8] <= r[7:0];
			end else begin
				res_q <= r[KW-1:0];
			end
		end
	end

	assign done   = (ph_q == L_DONE);
	assign result = res_q;

endmodule

@@ rtl/core/weighted_keyframe_interpolator.sv @@
// Weighted keyframe interpolator top level: command sequencer, configuration
// registers and result register. Depends on wki_pkg, wki_mem, wki_div, wki_lerp.
//
// The block keeps up to MAX_KEYS keyframe values and segment weights in a
// small synchronous memory with one registered read port, and answers every
// input beat with exactly one result beat. It works on one command at a time;
// a new command is taken while the previous result still waits in the output
// register. A write command rebuilds the stored total weight by walking the
// weight memory over the n-1 segments, n being the effective key count, with
// an address step and then a data step per entry. A rejected write goes
// straight to the output stage. An evaluate in uniform mode takes one
// multiply, two key reads and one interpolation pass, and a colour four
// passes, whose byte lanes go through the same interpolation unit in turn.
// In weighted mode a segment walk, with a read and a check per visited
// segment, and for a hit segment the serial divider come in addition. A
// write of key_count also rebuilds the total weight, and while it does the
// block takes no input beat. Configuration writes are taken only while the
// block is idle, and an input beat waits while a configuration write is
// offered. Key values read before they were written are undefined; weights
// read as zero until written.
module weighted_keyframe_interpolator #(
	parameter int MAX_KEYS  = wki_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = wki_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wki_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wki_pkg::CFG_DATA_W-1:0]      cfg_data,
	// command channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wki_pkg::CMD_W-1:0]           cmd,
	input  logic [wki_pkg::KIDX_W-1:0]          key_index,
	input  logic signed [wki_pkg::KVAL_W-1:0]   key_value,
	input  logic [wki_pkg::WGT_W-1:0]           segment_weight,
	input  logic [FRAC_BITS:0]                  fraction,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wki_pkg::KVAL_W-1:0]   value,
	output logic [wki_pkg::KIDX_W-1:0]          frame_index,
	output logic                                status
);

	localparam int IDX_W  = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int FR_W   = FRAC_BITS + 1;
	localparam int TOT_W  = wki_pkg::TOT_W;
	localparam int WGT_W  = wki_pkg::WGT_W;
	localparam int KW     = wki_pkg::KVAL_W;
	localparam int ACC_W  = WGT_W + IDX_W;
	localparam int WF_W   = FR_W + TOT_W;
	localparam int NUM_W  = WGT_W + FRAC_BITS;
	localparam int CMP_W  = (WF_W > ACC_W + FRAC_BITS) ? WF_W : ACC_W + FRAC_BITS;
	localparam int EW     = (wki_pkg::KCNT_W > CNT_W) ? wki_pkg::KCNT_W : CNT_W;
	localparam int IW     = (wki_pkg::KIDX_W > CNT_W) ? wki_pkg::KIDX_W : CNT_W;

	localparam logic [FR_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_TOT_RD  = 4'd1;
	localparam logic [3:0] S_TOT_ACC = 4'd2;
	localparam logic [3:0] S_EVAL    = 4'd3;
	localparam logic [3:0] S_SEL     = 4'd4;
	localparam logic [3:0] S_WK_RD   = 4'd5;
	localparam logic [3:0] S_WK_CHK  = 4'd6;
	localparam logic [3:0] S_DIV     = 4'd7;
	localparam logic [3:0] S_K0      = 4'd8;
	localparam logic [3:0] S_K1      = 4'd9;
	localparam logic [3:0] S_K2      = 4'd10;
	localparam logic [3:0] S_LERP    = 4'd11;
	localparam logic [3:0] S_OUT     = 4'd12;

	// Control and configuration state.
	logic [3:0]                  state_q;
	logic [wki_pkg::KCNT_W-1:0]  kcnt_q;
	logic [wki_pkg::KIND_W-1:0]  kind_q;
	logic                        usew_q;
	logic [TOT_W-1:0]            total_q;
	logic                        report_q;
	logic                        out_valid_q;

	// Working registers of the current command.
	logic [TOT_W-1:0]            tacc_q;
	logic [CNT_W-1:0]            walk_q;
	logic [ACC_W-1:0]            acc_q;
	logic [FR_W-1:0]             f_q;
	logic [WF_W-1:0]             prod_q;
	logic [IDX_W-1:0]            i0_q;
	logic [IDX_W-1:0]            i1_q;
	logic [FR_W-1:0]             t_q;
	logic [KW-1:0]               ka_q;
	logic [KW-1:0]               res_value_q;
	logic [wki_pkg::KIDX_W-1:0]  res_frame_q;
	logic                        res_status_q;
	logic [KW-1:0]               out_value_q;
	logic [wki_pkg::KIDX_W-1:0]  out_frame_q;
	logic                        out_status_q;

	// Effective key count: zero counts as one, anything above MAX_KEYS as MAX_KEYS.
	logic [EW-1:0]    kc_ext;
	logic [EW-1:0]    n_ext;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] nm1;
	logic [CNT_W-1:0] nm2;

	always_comb begin
		kc_ext = EW'(kcnt_q);
		if (kc_ext == '0) begin
			n_ext = EW'(1);
		end else if (kc_ext > EW'(MAX_KEYS)) begin
			n_ext = EW'(MAX_KEYS);
		end else begin
			n_ext = kc_ext;
		end
	end

	assign n   = n_ext[CNT_W-1:0];
	assign nm1 = n - 1'b1;
	assign nm2 = n - CNT_W'(2);

	// Handshakes. A configuration beat wins over a command beat in the same cycle.
	logic in_acc;
	logic cfg_acc;
	logic out_free;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;

	logic reject;
	assign reject = (IW'(key_index) >= IW'(n)) || (segment_weight == '0);

	// Memory ports.
	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [IW-1:0]     kidx_ext;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic [KW-1:0]     mem_key;
	logic [WGT_W-1:0]  mem_wgt;

	assign kidx_ext    = IW'(key_index);
	assign mem_wr_en   = in_acc && (cmd == wki_pkg::CMD_WRITE) && !reject;
	assign mem_wr_addr = kidx_ext[IDX_W-1:0];

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = walk_q[IDX_W-1:0];
		case (state_q)
			S_TOT_RD, S_WK_RD: mem_rd_en = 1'b1;
			S_K0: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = i0_q;
			end
			S_K1: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = i1_q;
			end
			default: mem_rd_en = 1'b0;
		endcase
	end

	wki_mem #(
		.MAX_KEYS (MAX_KEYS),
		.IDX_W    (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_key  (key_value),
		.wr_wgt  (segment_weight),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_key  (mem_key),
		.rd_wgt  (mem_wgt)
	);

	// Walk bookkeeping: the walk covers segments 0 .. n-2.
	logic           walk_more;
	logic [TOT_W:0] tsum;
	logic [TOT_W-1:0] tsum_sat;

	assign walk_more = ({1'b0, walk_q} + 1'b1) < {1'b0, n};
	assign tsum      = {1'b0, tacc_q} + (TOT_W+1)'(mem_wgt);
	assign tsum_sat  = (tsum > {1'b0, wki_pkg::TOT_MAX}) ? wki_pkg::TOT_MAX : tsum[TOT_W-1:0];

	// Weighted segment search: the first segment whose cumulative weight,
	// scaled to the fraction grid, reaches the scaled progress.
	logic [ACC_W-1:0] acc_new;
	logic [CMP_W-1:0] wf_ext;
	logic [CMP_W-1:0] end_sh;
	logic [CMP_W-1:0] start_sh;
	logic [CMP_W-1:0] num_full;
	logic             seg_hit;

	assign acc_new  = acc_q + ACC_W'(mem_wgt);
	assign wf_ext   = CMP_W'(prod_q);
	assign end_sh   = CMP_W'({acc_new, {FRAC_BITS{1'b0}}});
	assign start_sh = CMP_W'({acc_q, {FRAC_BITS{1'b0}}});
	assign num_full = wf_ext - start_sh;
	assign seg_hit  = wf_ext <= end_sh;

	logic             div_start;
	logic             div_done;
	logic [FR_W-1:0]  div_quo;

	assign div_start = (state_q == S_WK_CHK) && seg_hit && (mem_wgt != '0);

	wki_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_full[NUM_W-1:0]),
		.den    (mem_wgt),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Uniform spacing: the integer part of fraction*(n-1) is the lower key.
	logic [CNT_W-1:0] u_raw;
	logic [CNT_W-1:0] u_i0;
	logic [CNT_W-1:0] u_i1;

	assign u_raw = prod_q[FRAC_BITS +: CNT_W];
	assign u_i0  = (u_raw > nm1) ? nm1 : u_raw;
	assign u_i1  = (u_i0 == nm1) ? nm1 : u_i0 + 1'b1;

	// Interpolation between the two selected keys. A segment that collapses
	// to one key interpolates with a zero fraction.
	logic             lerp_start;
	logic             lerp_done;
	logic [KW-1:0]    lerp_res;
	logic [FR_W-1:0]  t_eff;
	logic [IW-1:0]    frame_ext;

	assign lerp_start = (state_q == S_K2);
	assign t_eff      = (i0_q == i1_q) ? '0 : t_q;
	assign frame_ext  = (f_q == ONE) ? IW'(i1_q) : IW'(i0_q);

	wki_lerp #(
		.FRAC_BITS (FRAC_BITS)
	) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.kind   (kind_q),
		.key_a  (ka_q),
		.key_b  (mem_key),
		.t      (t_eff),
		.done   (lerp_done),
		.result (lerp_res)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kcnt_q   <= wki_pkg::KCNT_RESET;
			kind_q   <= wki_pkg::KIND_RESET;
			usew_q   <= 1'b0;
			total_q  <= '0;
			report_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						unique case (cfg_index)
							wki_pkg::REG_KEY_COUNT: begin
								kcnt_q   <= cfg_data[wki_pkg::KCNT_W-1:0];
								report_q <= 1'b0;
								state_q  <= S_TOT_RD;
							end
							wki_pkg::REG_VALUE_KIND: kind_q <= cfg_data[wki_pkg::KIND_W-1:0];
							wki_pkg::REG_USE_WEIGHTS: usew_q <= cfg_data[0];
							default: usew_q <= usew_q;
						endcase
					end else if (in_acc) begin
						if (cmd == wki_pkg::CMD_WRITE) begin
							if (reject) begin
								state_q <= S_OUT;
							end else begin
								report_q <= 1'b1;
								state_q  <= S_TOT_RD;
							end
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_TOT_RD: begin
					if (walk_more) begin
						state_q <= S_TOT_ACC;
					end else begin
						total_q <= tacc_q;
						state_q <= report_q ? S_OUT : S_IDLE;
					end
				end
				S_TOT_ACC: state_q <= S_TOT_RD;
				S_EVAL:    state_q <= S_SEL;
				S_SEL: begin
					if (n == CNT_W'(1) || !usew_q || f_q == ONE) begin
						state_q <= S_K0;
					end else begin
						state_q <= S_WK_RD;
					end
				end
				S_WK_RD:  state_q <= walk_more ? S_WK_CHK : S_K0;
				S_WK_CHK: begin
					if (seg_hit) begin
						state_q <= (mem_wgt != '0) ? S_DIV : S_K0;
					end else begin
						state_q <= S_WK_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_K0;
					end
				end
				S_K0: state_q <= S_K1;
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_LERP;
				S_LERP: begin
					if (lerp_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the current command.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				walk_q <= '0;
				tacc_q <= '0;
				acc_q  <= '0;
				f_q    <= (fraction > ONE) ? ONE : fraction;
				res_value_q  <= '0;
				res_frame_q  <= '0;
				res_status_q <= (cmd == wki_pkg::CMD_WRITE && reject) ?
					wki_pkg::STATUS_REJECT : wki_pkg::STATUS_OK;
			end
			S_TOT_ACC: begin
				tacc_q <= tsum_sat;
				walk_q <= walk_q + 1'b1;
			end
			S_EVAL: begin
				prod_q <= f_q * (usew_q ? total_q : TOT_W'(nm1));
			end
			S_SEL: begin
				if (n == CNT_W'(1)) begin
					i0_q <= '0;
					i1_q <= '0;
					t_q  <= '0;
				end else if (!usew_q) begin
					i0_q <= u_i0[IDX_W-1:0];
					i1_q <= u_i1[IDX_W-1:0];
					t_q  <= {1'b0, prod_q[FRAC_BITS-1:0]};
				end else begin
					i0_q <= nm2[IDX_W-1:0];
					i1_q <= nm1[IDX_W-1:0];
					t_q  <= ONE;
				end
			end
			S_WK_CHK: begin
				if (seg_hit) begin
					i0_q <= walk_q[IDX_W-1:0];
					i1_q <= IDX_W'(walk_q + 1'b1);
					t_q  <= '0;
				end else begin
					acc_q  <= acc_new;
					walk_q <= walk_q + 1'b1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					t_q <= (div_quo > ONE) ? ONE : div_quo;
				end
			end
			S_K1: begin
				ka_q <= mem_key;
			end
			S_LERP: begin
				if (lerp_done) begin
					res_value_q <= lerp_res;
					res_frame_q <= frame_ext[wki_pkg::KIDX_W-1:0];
				end
			end
			default: begin
				ka_q <= ka_q;
			end
		endcase
	end

	// Output register: loaded when the result is ready and the slot is free.
	logic out_load;
	assign out_load = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_frame_q  <= res_frame_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = out_value_q;
	assign frame_index = out_frame_q;
	assign status      = out_status_q;

endmodule
